/* sv/pbra_pkg.sv */
// Package: constants, types and helpers for the page bitmap range allocator.
package pbra_pkg;

  localparam int NumPages  = 4096;
  localparam int WordBits  = 64;
  localparam int NumWords  = NumPages / WordBits;
  localparam int PageW     = 12;
  localparam int CountW    = 13;
  localparam int WordAddrW = 6;
  localparam int BitW      = 6;
  localparam logic [PageW-1:0] TopPage = 12'hFFF;
  localparam logic [PageW-1:0] ReservedReset = 12'd16;
  localparam logic [PageW-1:0] LowTopReset = 12'd2047;

  localparam logic [1:0] FuncAlloc  = 2'd0;
  localparam logic [1:0] FuncMark   = 2'd1;
  localparam logic [1:0] FuncFree   = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoRun    = 2'd1;
  localparam logic [1:0] StReserved = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  localparam logic [1:0] RegTopDown  = 2'd0;
  localparam logic [1:0] RegReserved = 2'd1;
  localparam logic [1:0] RegLowTop   = 2'd2;

  // memory request from the sequencer to the map RAM
  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [WordAddrW-1:0] addr;
    logic [WordBits-1:0]  wdata;
  } map_req_t;

  // default page map word content after reset
  function automatic logic [WordBits-1:0] reset_word(input logic [WordAddrW-1:0] a);
    logic [WordBits-1:0] w;
    w = '0;
    if (a == '0) w[15:0] = 16'hFFFF;
    if (a == WordAddrW'(NumWords - 1)) w[WordBits-1] = 1'b1;
    return w;
  endfunction

endpackage

/* sv/pbra_map_ram.sv */
// Page used map: one word per 64 pages, registered read, with reset-initializing sweep.
module pbra_map_ram (
  input  logic                            clk,
  input  logic                            rst,
  input  pbra_pkg::map_req_t              req,
  output logic [pbra_pkg::WordBits-1:0]   rdata,
  output logic                            init_done
);
  logic [pbra_pkg::WordBits-1:0]  mem [pbra_pkg::NumWords];
  logic [pbra_pkg::WordAddrW:0]   sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (!sweep[pbra_pkg::WordAddrW]) begin
      sweep <= sweep + 1'b1;
    end
  end
  assign init_done = sweep[pbra_pkg::WordAddrW];

  always_ff @(posedge clk) begin
    if (!init_done) begin
      mem[sweep[pbra_pkg::WordAddrW-1:0]] <=
        pbra_pkg::reset_word(sweep[pbra_pkg::WordAddrW-1:0]);
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) rdata <= mem[req.addr];
  end
endmodule

/* sv/pbra_seq.sv */
// Request sequencer: page-by-page search and range update over the map RAM.
module pbra_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    func,
  input  logic [pbra_pkg::PageW-1:0]    page_index,
  input  logic [pbra_pkg::CountW-1:0]   page_count,
  input  logic                          want_low,
  input  logic                          top_down,
  input  logic [pbra_pkg::PageW-1:0]    reserved,
  input  logic [pbra_pkg::PageW-1:0]    low_top,
  output logic                          busy,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [pbra_pkg::PageW-1:0]    result_page,
  output pbra_pkg::map_req_t            req,
  input  logic [pbra_pkg::WordBits-1:0] rdata
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CHK = 4'd2, S_WRD = 4'd3,
                         S_WRM = 4'd4, S_DONE = 4'd5;

  logic [3:0] state;
  logic       op_alloc, op_set, retried, low_q;
  // signed-ish 14-bit window to tolerate going below zero / above top
  logic [13:0] s, p;
  logic [pbra_pkg::CountW-1:0] n, o;
  logic [13:0] wp;
  logic [pbra_pkg::CountW-1:0] wn;
  logic [pbra_pkg::PageW-1:0] cursor;
  logic [pbra_pkg::PageW-1:0] base, ltop;
  logic        pbusy;
  logic [pbra_pkg::WordBits-1:0] wmask;
  logic        cur_hi;

  assign base = reserved;
  assign ltop = low_top;
  assign busy = (state != S_IDLE);
  assign pbusy = (p[13:12] != 2'b00) || (p[11:0] < base) || (p[11:0] == pbra_pkg::TopPage)
                 || rdata[p[pbra_pkg::BitW-1:0]];
  assign cur_hi = want_low && (cursor >= ltop);

  // current page probed: down: s-o, up: s+o
  always_comb begin
    wmask = '0;
    for (int b = 0; b < pbra_pkg::WordBits; b++) begin
      if ({wp[11:6], 6'(b)} >= wp[11:0] &&
          14'({wp[11:6], 6'(b)}) < wp + 14'(wn) && wp[11:6] == wp[11:6])
        wmask[b] = 1'b1;
    end
  end

  always_comb begin
    req = '0;
    unique case (state)
      S_RD:  begin req.rd = 1'b1; req.addr = p[11:6]; end
      S_WRD: begin req.rd = 1'b1; req.addr = wp[11:6]; end
      S_WRM: begin
        req.wr = 1'b1; req.addr = wp[11:6];
        req.wdata = op_set ? (rdata | wmask) : (rdata & ~wmask);
      end
      default: ;
    endcase
  end

  // pages from wp to the end of the word containing wp
  logic [6:0] room;
  assign room = 7'd64 - 7'(wp[5:0]);

  function automatic logic [13:0] stp(input logic [13:0] a, input logic td,
                                      input logic [pbra_pkg::CountW-1:0] k);
    return td ? a - 14'(k) : a + 14'(k);
  endfunction

  logic [13:0] s2;
  assign s2 = top_down ? s - 14'(o) - 14'd1 : s + 14'(o) + 14'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      cursor <= pbra_pkg::TopPage;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          op_alloc <= (func == pbra_pkg::FuncAlloc);
          op_set <= (func == pbra_pkg::FuncMark);
          low_q <= want_low;
          retried <= 1'b0;
          n <= page_count;
          o <= '0;
          status <= pbra_pkg::StOk;
          result_page <= '0;
          if (func == pbra_pkg::FuncAlloc) begin
            if (page_count == '0) begin
              status <= pbra_pkg::StNoRun; state <= S_DONE;
            end else begin
              s <= {2'b00, cur_hi ? ltop : cursor};
              p <= {2'b00, cur_hi ? ltop : cursor};
              state <= S_RD;
              if (!top_down && ({1'b0, cur_hi ? ltop : cursor} + page_count
                  > {1'b0, pbra_pkg::TopPage})) state <= S_CHK;
            end
          end else if (func == pbra_pkg::FuncMark || func == pbra_pkg::FuncFree) begin
            if ({2'b00, page_index} + {1'b0, page_count} > 14'(pbra_pkg::TopPage)) begin
              status <= pbra_pkg::StOverflow; state <= S_DONE;
            end else if (page_index < reserved) begin
              status <= (func == pbra_pkg::FuncMark) ? pbra_pkg::StReserved : pbra_pkg::StOk;
              state <= S_DONE;
            end else if (page_count == '0) begin
              state <= S_DONE;
            end else begin
              wp <= {2'b00, page_index}; wn <= page_count; state <= S_WRD;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          // S_CHK without preceding read on up-overflow: treat as fail
          logic fail_now;
          fail_now = 1'b0;
          if (!top_down && (s + 14'(n) > 14'(pbra_pkg::TopPage))) fail_now = 1'b1;
          else if (!pbusy) begin
            if (o + 1'b1 == n) begin
              // hit
              wp <= top_down ? s - 14'(n) + 14'd1 : s;
              wn <= n;
              result_page <= top_down ? 12'(s - 14'(n) + 14'd1) : s[11:0];
              cursor <= top_down ? 12'(s - 14'(n) + 14'd1)
                      : ((s + 14'(n) > 14'(pbra_pkg::TopPage)) ? pbra_pkg::TopPage
                         : 12'(s + 14'(n)));
              op_set <= 1'b1;
              state <= S_WRD;
            end else begin
              o <= o + 1'b1;
              p <= stp(s, top_down, o + 1'b1);
              state <= S_RD;
            end
          end else begin
            // restart
            if (top_down) begin
              if (14'(o) + 14'd1 > s || s2 < {2'b00, base}) fail_now = 1'b1;
            end else begin
              if (s2 >= 14'(pbra_pkg::TopPage) ||
                  s2 + 14'(n) > 14'(pbra_pkg::TopPage)) fail_now = 1'b1;
            end
            if (!fail_now) begin
              s <= s2; p <= s2; o <= '0; state <= S_RD;
            end
          end
          if (fail_now) begin
            if (retried) begin
              status <= pbra_pkg::StNoRun; state <= S_DONE;
            end else begin
              logic [11:0] rs;
              rs = low_q ? ltop : (top_down ? pbra_pkg::TopPage : base);
              retried <= 1'b1;
              s <= {2'b00, rs}; p <= {2'b00, rs}; o <= '0;
              state <= (top_down && rs < base) ? S_CHK : S_RD;
              if (top_down && rs < base) begin
                status <= pbra_pkg::StNoRun; state <= S_DONE;
              end
            end
          end
        end
        S_WRD: state <= S_WRM;
        S_WRM: begin
          if (14'(wn) <= 14'(room)) state <= S_DONE;
          else begin
            wp <= wp + 14'(room); wn <= wn - 13'(room); state <= S_WRD;
          end
        end
        S_DONE: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) req.wr |-> !req.rd)
    else $error("map read and write in same cycle");
  assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && op_alloc && status == pbra_pkg::StOk) |=> cursor == $past(cursor))
    else $error("cursor moved after completion");
endmodule

/* sv/page_bitmap_range_allocator_core.sv */
// Top level of the page bitmap range allocator.
// Usage:
//   s_axis_*: requests. tdata = {want_low, page_count, page_index, func} from bit 0.
//   m_axis_*: one result per request. tdata = {result_page, status} from bit 0.
//   cfg_we/cfg_addr/cfg_wdata: register writes (0 top-down, 1 reserved, 2 low top).
// Timing: mark/free requests read and then write each 64-page word touched, then
// report the result. Allocate probes one page at a time through the map memory port,
// reading the word of each page checked on each pass, then does the same writes;
// its run time depends on map content.
// One request is in flight at a time; a new request is accepted only once the
// sequencer is idle and the output register is empty or being read that cycle.
// After reset the map memory is initialized by a sweep over all 64 words, during
// which no request is accepted. A stalled result blocks the next request until the
// receiver takes it.
module page_bitmap_range_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // func[1:0], page_index[13:2], page_count[26:14], want_low[27]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[1:0], result_page[13:2]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);
  logic        top_down;
  logic [11:0] reserved, low_top, res_c, low_c;
  logic        busy, done, init_done;
  logic [1:0]  status;
  logic [11:0] result_page;
  pbra_pkg::map_req_t req;
  logic [pbra_pkg::WordBits-1:0] rdata;
  logic        start;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_down <= 1'b1;
      reserved <= pbra_pkg::ReservedReset;
      low_top <= pbra_pkg::LowTopReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pbra_pkg::RegTopDown:  top_down <= cfg_wdata[0];
        pbra_pkg::RegReserved: reserved <= cfg_wdata;
        pbra_pkg::RegLowTop:   low_top <= cfg_wdata;
        default: ;
      endcase
    end
  end
  assign res_c = reserved;
  assign low_c = low_top;

  // accept when idle and the output slot will be free by completion
  assign s_axis_tready = init_done && !busy && !done && (!m_axis_tvalid || m_axis_tready);
  assign start = s_axis_tvalid && s_axis_tready;

  pbra_map_ram u_ram (
    .clk(clk), .rst(rst), .req(req), .rdata(rdata), .init_done(init_done)
  );

  pbra_seq u_seq (
    .clk(clk), .rst(rst), .start(start),
    .func(s_axis_tdata[1:0]), .page_index(s_axis_tdata[13:2]),
    .page_count(s_axis_tdata[26:14]), .want_low(s_axis_tdata[27]),
    .top_down(top_down), .reserved(res_c), .low_top(low_c),
    .busy(busy), .done(done), .status(status), .result_page(result_page),
    .req(req), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (done) m_axis_tdata <= {2'b00, result_page, status};
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("request accepted while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending one");
  assert property (@(posedge clk) disable iff (rst) !init_done |-> !s_axis_tready)
    else $error("ready during map init");
endmodule
